// ===== hdl/command_chunk_framer_defines.svh =====
// Assertion macros for the command chunk framer checker.
// Depends on: nothing; the using scope provides aclk and aresetn.
`ifndef COMMAND_CHUNK_FRAMER_DEFINES_SVH
`define COMMAND_CHUNK_FRAMER_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define CCF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ccf: same-cycle check failed");

// Next-cycle implication, sampled on aclk, off during reset.
`define CCF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ccf: next-cycle check failed");

`endif

// ===== hdl/ccf_pkg.sv =====
// Shared types and constants for the command chunk framer.
// Depends on: nothing.
package ccf_pkg;

    localparam int MAX_DATA_WORDS = 200;
    localparam int ADDR_W         = $clog2(MAX_DATA_WORDS);
    localparam int CNT_W          = $clog2(MAX_DATA_WORDS + 4);
    localparam int WORD_W         = 32;
    localparam int TAG_W          = 16;
    localparam int LEN_W          = 16;

    localparam logic [TAG_W-1:0] TAG_RESET   = TAG_W'(112);
    localparam logic [CNT_W-1:0] MAX_CMD_LEN = CNT_W'(MAX_DATA_WORDS - 1);

    typedef enum logic [1:0] {
        ACT_PUSH = 2'd0,
        ACT_END  = 2'd1,
        ACT_PULL = 2'd2,
        ACT_NONE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        PH_COLLECT = 2'd0,
        PH_DRAIN   = 2'd1,
        PH_FINAL   = 2'd2,
        PH_ERROR   = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_REFUSED  = 3'd1,
        ST_LENERR   = 3'd2,
        ST_FINISHED = 3'd3,
        ST_EMPTY    = 3'd4
    } status_t;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              use_mem;
        logic              word_valid;
        logic              frame_last;
        status_t           status;
    } result_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [WORD_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } mem_req_t;

endpackage

// ===== hdl/ccf_frame_ram.sv =====
// Simple dual-port RAM, one write and one registered read port.
// Depends on: nothing.
module ccf_frame_ram #(
    parameter int DEPTH  = 200,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/ccf_ctrl.sv =====
// Framer control: phase, counters, running XOR, tag register, store access.
// Depends on: ccf_pkg.
module ccf_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [ccf_pkg::TAG_W-1:0]     cfg_wr_data,
    input  logic                          accept,
    input  logic [1:0]                    action,
    input  logic [ccf_pkg::WORD_W-1:0]    data_word,
    output ccf_pkg::result_t              res,
    output ccf_pkg::mem_req_t             mem_req
);

    ccf_pkg::phase_t                phase_reg, phase_next;
    logic [ccf_pkg::CNT_W-1:0]      used_reg, used_next;
    logic [ccf_pkg::CNT_W-1:0]      left_reg, left_next;
    logic [ccf_pkg::CNT_W-1:0]      pos_reg, pos_next;
    logic [ccf_pkg::WORD_W-1:0]     xor_reg, xor_next;
    logic [ccf_pkg::TAG_W-1:0]      tag_reg;

    logic [ccf_pkg::LEN_W-1:0]      len;
    logic [ccf_pkg::CNT_W-1:0]      len_lo;
    logic                           len_bad;
    logic                           no_fit;
    logic [ccf_pkg::CNT_W-1:0]      n1, n2;
    logic [ccf_pkg::CNT_W-1:0]      p_off;
    logic [ccf_pkg::WORD_W-1:0]     hdr;
    logic                           store;

    assign len     = data_word[ccf_pkg::WORD_W-1 -: ccf_pkg::LEN_W];
    assign len_lo  = len[ccf_pkg::CNT_W-1:0];
    assign len_bad = (len[ccf_pkg::LEN_W-1:ccf_pkg::CNT_W] != '0)
                   || (len_lo < ccf_pkg::CNT_W'(2))
                   || (len_lo > ccf_pkg::MAX_CMD_LEN);
    assign no_fit  = ({1'b0, used_reg} + {1'b0, len_lo})
                   > (ccf_pkg::CNT_W + 1)'(ccf_pkg::MAX_DATA_WORDS);
    assign n1      = used_reg + ccf_pkg::CNT_W'(1);
    assign n2      = used_reg + ccf_pkg::CNT_W'(2);
    assign p_off   = pos_reg - ccf_pkg::CNT_W'(2);
    assign hdr     = {ccf_pkg::LEN_W'(used_reg) + ccf_pkg::LEN_W'(4), tag_reg};

    always_comb begin
        phase_next     = phase_reg;
        used_next      = used_reg;
        left_next      = left_reg;
        pos_next       = pos_reg;
        xor_next       = xor_reg;
        store          = 1'b0;
        res.word       = '0;
        res.use_mem    = 1'b0;
        res.word_valid = 1'b0;
        res.frame_last = 1'b0;
        res.status     = ccf_pkg::ST_EMPTY;

        case (ccf_pkg::action_t'(action))
            ccf_pkg::ACT_PUSH: begin
                case (phase_reg)
                    ccf_pkg::PH_ERROR: res.status = ccf_pkg::ST_LENERR;
                    ccf_pkg::PH_FINAL: begin
                        res.status = (used_reg != '0) ? ccf_pkg::ST_REFUSED
                                                      : ccf_pkg::ST_FINISHED;
                    end
                    ccf_pkg::PH_DRAIN: res.status = ccf_pkg::ST_REFUSED;
                    default: begin
                        res.status = ccf_pkg::ST_OK;
                        if (left_reg != '0) begin
                            store     = 1'b1;
                            left_next = left_reg - ccf_pkg::CNT_W'(1);
                        end else if (len == '0) begin
                            phase_next = ccf_pkg::PH_FINAL;
                        end else if (len_bad) begin
                            used_next  = '0;
                            left_next  = '0;
                            xor_next   = '0;
                            pos_next   = '0;
                            phase_next = ccf_pkg::PH_ERROR;
                            res.status = ccf_pkg::ST_LENERR;
                        end else if (no_fit && used_reg != '0) begin
                            phase_next = ccf_pkg::PH_DRAIN;
                            res.status = ccf_pkg::ST_REFUSED;
                        end else begin
                            store     = 1'b1;
                            left_next = len_lo - ccf_pkg::CNT_W'(2);
                        end
                    end
                endcase
            end
            ccf_pkg::ACT_END: begin
                case (phase_reg)
                    ccf_pkg::PH_ERROR: res.status = ccf_pkg::ST_LENERR;
                    ccf_pkg::PH_FINAL: res.status = ccf_pkg::ST_FINISHED;
                    default: begin
                        left_next  = '0;
                        phase_next = ccf_pkg::PH_FINAL;
                        res.status = ccf_pkg::ST_OK;
                    end
                endcase
            end
            ccf_pkg::ACT_PULL: begin
                if (phase_reg == ccf_pkg::PH_ERROR) begin
                    res.status = ccf_pkg::ST_LENERR;
                end else if ((phase_reg == ccf_pkg::PH_DRAIN
                              || phase_reg == ccf_pkg::PH_FINAL) && used_reg != '0) begin
                    res.word_valid = 1'b1;
                    res.status     = ccf_pkg::ST_OK;
                    pos_next       = pos_reg + ccf_pkg::CNT_W'(1);
                    if (pos_reg == '0) begin
                        res.word = hdr;
                    end else if (pos_reg == ccf_pkg::CNT_W'(1)) begin
                        res.word = ccf_pkg::WORD_W'(n1);
                    end else if (pos_reg < n2) begin
                        res.use_mem = 1'b1;
                    end else if (pos_reg == n2) begin
                        res.word = '0;
                    end else begin
                        res.word       = hdr ^ ccf_pkg::WORD_W'(n1) ^ xor_reg;
                        res.frame_last = 1'b1;
                        used_next      = '0;
                        left_next      = '0;
                        xor_next       = '0;
                        pos_next       = '0;
                        if (phase_reg == ccf_pkg::PH_DRAIN) begin
                            phase_next = ccf_pkg::PH_COLLECT;
                        end
                    end
                end
            end
            default: res.status = ccf_pkg::ST_EMPTY;
        endcase

        if (store) begin
            used_next = used_reg + ccf_pkg::CNT_W'(1);
            xor_next  = xor_reg ^ data_word;
        end
    end

    // Writes occur only while collecting and reads only in the drain and final phases,
    // so the same entry is never written and read in overlapping cycles.
    assign mem_req.wr_en   = accept && store;
    assign mem_req.wr_addr = used_reg[ccf_pkg::ADDR_W-1:0];
    assign mem_req.wr_data = data_word;
    assign mem_req.rd_en   = accept && res.use_mem;
    assign mem_req.rd_addr = p_off[ccf_pkg::ADDR_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= ccf_pkg::PH_COLLECT;
            used_reg  <= '0;
            left_reg  <= '0;
            pos_reg   <= '0;
            xor_reg   <= '0;
            tag_reg   <= ccf_pkg::TAG_RESET;
        end else begin
            if (cfg_wr_en) begin
                tag_reg <= cfg_wr_data;
            end
            if (accept) begin
                phase_reg <= phase_next;
                used_reg  <= used_next;
                left_reg  <= left_next;
                pos_reg   <= pos_next;
                xor_reg   <= xor_next;
            end
        end
    end

endmodule

// ===== hdl/command_chunk_framer.sv =====
// Command chunk framer: an accepted input is registered in p1 and then in the
// output stage. Throughput: one transaction per cycle while m_ready does not
// stall the output, set by the state update and the registered store read.
// Reset clears phase, counters, XOR, tag (to 112) and pipeline valids;
// frame store content is left undefined and needs no clearing pass.
// Depends on: ccf_pkg, ccf_ctrl, ccf_frame_ram.
module command_chunk_framer (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [ccf_pkg::TAG_W-1:0]   cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_action,
    input  logic [ccf_pkg::WORD_W-1:0]  s_data_word,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [ccf_pkg::WORD_W-1:0]  m_out_word,
    output logic                        m_word_valid,
    output logic                        m_frame_last,
    output logic [2:0]                  m_status
);

    ccf_pkg::result_t               res;
    ccf_pkg::mem_req_t              mem_req;
    logic [ccf_pkg::WORD_W-1:0]     rd_data;
    logic                           accept;
    logic                           p1_adv;

    logic                           p1_valid_reg, p1_valid_next;
    ccf_pkg::result_t               p1_res_reg;
    logic                           out_valid_reg, out_valid_next;
    logic [ccf_pkg::WORD_W-1:0]     out_word_reg;
    logic                           out_wvalid_reg;
    logic                           out_last_reg;
    logic [2:0]                     out_status_reg;

    assign p1_adv  = !out_valid_reg || m_ready;
    assign s_ready = !p1_valid_reg || p1_adv;
    assign accept  = s_valid && s_ready;

    ccf_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .action      (s_action),
        .data_word   (s_data_word),
        .res         (res),
        .mem_req     (mem_req)
    );

    ccf_frame_ram #(
        .DEPTH (ccf_pkg::MAX_DATA_WORDS),
        .WIDTH (ccf_pkg::WORD_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (mem_req.wr_en),
        .wr_addr (mem_req.wr_addr),
        .wr_data (mem_req.wr_data),
        .rd_en   (mem_req.rd_en),
        .rd_addr (mem_req.rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        if (accept) begin
            p1_valid_next = 1'b1;
        end else if (p1_adv) begin
            p1_valid_next = 1'b0;
        end else begin
            p1_valid_next = p1_valid_reg;
        end
        out_valid_next = p1_adv ? p1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg  <= p1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_res_reg <= res;
        end
        if (p1_adv && p1_valid_reg) begin
            out_word_reg   <= p1_res_reg.use_mem ? rd_data : p1_res_reg.word;
            out_wvalid_reg <= p1_res_reg.word_valid;
            out_last_reg   <= p1_res_reg.frame_last;
            out_status_reg <= p1_res_reg.status;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_out_word   = out_word_reg;
    assign m_word_valid = out_wvalid_reg;
    assign m_frame_last = out_last_reg;
    assign m_status     = out_status_reg;

endmodule

// ===== hdl/ccf_checker.sv =====
// Port-level checks for command_chunk_framer, attached by bind.
// Depends on: ccf_pkg, command_chunk_framer_defines.svh.
`include "command_chunk_framer_defines.svh"

module ccf_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic [1:0]                  s_action,
    input logic [ccf_pkg::WORD_W-1:0]  s_data_word,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [ccf_pkg::WORD_W-1:0]  m_out_word,
    input logic                        m_word_valid,
    input logic                        m_frame_last,
    input logic [2:0]                  m_status
);

    `CCF_ASSERT_NEXT(a_in_hold, s_valid && !s_ready, s_valid && $stable(s_action) && $stable(s_data_word))
    `CCF_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_out_word) && $stable(m_status))
    `CCF_ASSERT_NOW(a_last_has_word, m_valid && m_frame_last, m_word_valid && m_status == ccf_pkg::ST_OK)
    `CCF_ASSERT_NOW(a_idle_word_zero, m_valid && !m_word_valid, m_out_word == '0)
    `CCF_ASSERT_NOW(a_word_ok, m_valid && m_word_valid, m_status == ccf_pkg::ST_OK)

endmodule

bind command_chunk_framer ccf_checker u_ccf_checker (.*);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for command_chunk_framer: packs random command streams,
// reads the frames back and compares every result against a cycle-free predictor.
// Depends on: ccf_pkg, command_chunk_framer.
module tb;
    import ccf_pkg::*;

    typedef struct {
        logic [WORD_W-1:0] word;
        logic              valid;
        logic              is_last;
        status_t           st;
    } frame_beat_t;

    class frame_scoreboard;
        logic [WORD_W-1:0] store [MAX_DATA_WORDS];
        int unsigned       used;
        int unsigned       left;
        int unsigned       rdpos;
        logic [WORD_W-1:0] xsum;
        logic [TAG_W-1:0]  tag;
        phase_t            ph;
        frame_beat_t       beats[$];
        int unsigned       errors;
        int unsigned       checked;

        function new();
            tag     = TAG_RESET;
            ph      = PH_COLLECT;
            errors  = 0;
            checked = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            used  = 0;
            left  = 0;
            rdpos = 0;
            xsum  = '0;
        endfunction

        function void store_word(logic [WORD_W-1:0] w);
            if (used < MAX_DATA_WORDS) begin
                store[used] = w;
                used++;
                xsum ^= w;
            end
        endfunction

        function status_t push_word(logic [WORD_W-1:0] w);
            int unsigned len;
            if (ph == PH_ERROR) return ST_LENERR;
            if (ph == PH_FINAL) return (used > 0) ? ST_REFUSED : ST_FINISHED;
            if (ph == PH_DRAIN) return ST_REFUSED;
            if (left > 0) begin
                store_word(w);
                left--;
                return ST_OK;
            end
            len = w[31:16];
            if (len == 0) begin
                ph = PH_FINAL;
                return ST_OK;
            end
            if (len < 2 || len > MAX_DATA_WORDS - 1) begin
                clear_frame();
                ph = PH_ERROR;
                return ST_LENERR;
            end
            if (used + len - 1 > MAX_DATA_WORDS - 1 && used > 0) begin
                ph = PH_DRAIN;
                return ST_REFUSED;
            end
            store_word(w);
            left = len - 2;
            return ST_OK;
        endfunction

        // Works out the result of one accepted transaction and queues it.
        function status_t note_input(action_t act, logic [WORD_W-1:0] w);
            frame_beat_t      b;
            logic [WORD_W-1:0] hdr;
            b.word    = '0;
            b.valid   = 1'b0;
            b.is_last = 1'b0;
            b.st      = ST_EMPTY;
            hdr       = {16'(used + 4), tag};
            case (act)
                ACT_PUSH: b.st = push_word(w);
                ACT_END: begin
                    if (ph == PH_ERROR) b.st = ST_LENERR;
                    else if (ph == PH_FINAL) b.st = ST_FINISHED;
                    else begin
                        left = 0;
                        ph   = PH_FINAL;
                        b.st = ST_OK;
                    end
                end
                ACT_PULL: begin
                    if (ph == PH_ERROR) b.st = ST_LENERR;
                    else if ((ph == PH_DRAIN || ph == PH_FINAL) && used > 0) begin
                        if (rdpos == 0) b.word = hdr;
                        else if (rdpos == 1) b.word = 32'(used + 1);
                        else if (rdpos < used + 2) b.word = store[rdpos - 2];
                        else if (rdpos == used + 2) b.word = '0;
                        else begin
                            b.word    = hdr ^ 32'(used + 1) ^ xsum;
                            b.is_last = 1'b1;
                        end
                        b.valid = 1'b1;
                        b.st    = ST_OK;
                        if (b.is_last) begin
                            clear_frame();
                            if (ph == PH_DRAIN) ph = PH_COLLECT;
                        end else begin
                            rdpos++;
                        end
                    end
                end
                default: b.st = ST_EMPTY;
            endcase
            beats.push_back(b);
            return b.st;
        endfunction

        function void check_result(logic [WORD_W-1:0] word, logic valid, logic is_last,
                                   logic [2:0] st);
            frame_beat_t b;
            if (beats.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word %h status %0d", $time, word, st);
                return;
            end
            b = beats.pop_front();
            checked++;
            if (word !== b.word) begin
                errors++;
                $display("%0t: out_word expected %h got %h", $time, b.word, word);
            end
            if (valid !== b.valid) begin
                errors++;
                $display("%0t: word_valid expected %b got %b", $time, b.valid, valid);
            end
            if (is_last !== b.is_last) begin
                errors++;
                $display("%0t: frame_last expected %b got %b", $time, b.is_last, is_last);
            end
            if (st !== b.st) begin
                errors++;
                $display("%0t: status expected %0d got %0d", $time, b.st, st);
            end
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              cfg_wr_en;
    logic [TAG_W-1:0]  cfg_wr_data;
    logic              s_valid;
    logic              s_ready;
    logic [1:0]        s_action;
    logic [WORD_W-1:0] s_data_word;
    logic              m_valid;
    logic              m_ready;
    logic [WORD_W-1:0] m_out_word;
    logic              m_word_valid;
    logic              m_frame_last;
    logic [2:0]        m_status;

    frame_scoreboard   sb;
    logic [WORD_W-1:0] cmd_q[$];
    int                src_idle;
    int                snk_stall;
    int unsigned       sent;
    int unsigned       tag_writes;

    always #5 aclk = ~aclk;

    command_chunk_framer dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_data_word  (s_data_word),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_word   (m_out_word),
        .m_word_valid (m_word_valid),
        .m_frame_last (m_frame_last),
        .m_status     (m_status)
    );

    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            m_ready <= (snk_stall == 0) || ($urandom_range(0, 99) >= snk_stall);
        end
    end

    // Signals are stable between the falling edge and the next rising edge.
    always @(negedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_out_word, m_word_valid, m_frame_last, m_status);
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic send_item(input action_t act, input logic [WORD_W-1:0] dat,
                             output status_t st);
        logic hit;
        while (src_idle != 0 && $urandom_range(0, 99) < src_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_action    <= act;
        s_data_word <= dat;
        do begin
            @(negedge aclk);
            hit = s_ready;
            @(posedge aclk);
        end while (!hit);
        st = sb.note_input(act, dat);
        sent++;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (sb.beats.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_tag(input logic [TAG_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.tag = v;
        tag_writes++;
    endtask

    task automatic drain_frame();
        status_t st;
        while (sb.ph == PH_DRAIN) send_item(ACT_PULL, $urandom, st);
    endtask

    task automatic build_command(input int len);
        cmd_q.delete();
        cmd_q.push_back({16'(len), 16'($urandom)});
        for (int i = 2; i < len; i++) cmd_q.push_back($urandom);
    endtask

    // Pushes the words of the current command, reading out frames on refusal.
    task automatic push_words(input int count);
        status_t st;
        int      n;
        n = 0;
        while (n < count && cmd_q.size() != 0) begin
            if (sb.ph == PH_DRAIN) drain_frame();
            send_item(ACT_PUSH, cmd_q[0], st);
            if (st == ST_OK) begin
                void'(cmd_q.pop_front());
                n++;
            end
        end
    endtask

    task automatic run_traffic(input int target);
        status_t st;
        int      done_cnt;
        int      pick;
        done_cnt = 0;
        while (done_cnt < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                case ($urandom_range(0, 2))
                    0: send_item(ACT_NONE, $urandom, st);
                    1: send_item(ACT_PULL, $urandom, st);
                    default: send_item(sb.ph == PH_DRAIN ? ACT_PUSH : ACT_NONE, $urandom, st);
                endcase
            end else if (sb.ph == PH_DRAIN) begin
                send_item(ACT_PULL, $urandom, st);
                done_cnt++;
            end else begin
                if (cmd_q.size() == 0) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 70) build_command($urandom_range(2, 8));
                    else if (pick < 92) build_command($urandom_range(9, 40));
                    else if (pick < 97) build_command($urandom_range(41, 198));
                    else build_command(MAX_DATA_WORDS - 1);
                end
                send_item(ACT_PUSH, cmd_q[0], st);
                if (st == ST_OK) begin
                    void'(cmd_q.pop_front());
                    done_cnt++;
                end
            end
        end
    endtask

    initial begin
        int                src_pct [4];
        int                snk_pct [4];
        logic [TAG_W-1:0]  tags [4];
        status_t           st;
        int                mode;
        string             ending;

        src_pct = '{0, 53, 0, 34};
        snk_pct = '{0, 0, 53, 34};
        tags    = '{TAG_RESET, 16'hFFFF, 16'($urandom), 16'h0001};
        sb         = new();
        sent       = 0;
        tag_writes = 0;
        src_idle   = 0;
        snk_stall  = 0;
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_valid     <= 1'b0;
        s_action    <= ACT_NONE;
        s_data_word <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_tag(16'hFFFF);

        // directed: empty pulls, shortest command, zero-length continuation,
        // refusal on overflow, pushes while pending, tag change mid read-out
        send_item(ACT_NONE, 32'hFFFF_FFFF, st);
        send_item(ACT_PULL, 32'h0, st);
        send_item(ACT_PUSH, 32'h0002_0000, st);
        send_item(ACT_PUSH, 32'h0003_ABCD, st);
        send_item(ACT_PUSH, 32'h0000_0000, st);
        send_item(ACT_PULL, 32'hFFFF_FFFF, st);
        send_item(ACT_NONE, 32'h0, st);
        send_item(ACT_PUSH, 32'h00C7_FFFF, st);
        send_item(ACT_PUSH, 32'hFFFF_FFFF, st);
        send_item(ACT_NONE, 32'h5A5A_A5A5, st);
        repeat (3) send_item(ACT_PULL, $urandom, st);
        settle();
        write_tag(16'h0000);
        drain_frame();
        build_command(MAX_DATA_WORDS - 1);

        for (int p = 0; p < 4; p++) begin
            settle();
            write_tag(tags[p]);
            src_idle  = src_pct[p];
            snk_stall = snk_pct[p];
            run_traffic(175);
        end

        settle();
        write_tag(16'($urandom));
        push_words(cmd_q.size());
        mode = $urandom_range(0, 3);
        case (mode)
            0: begin
                ending = "end of data inside a command";
                build_command(6);
                push_words(3);
                send_item(ACT_END, $urandom, st);
            end
            1: begin
                ending = "end of data while a frame is pending";
                do send_item(ACT_PUSH, {16'd199, 16'($urandom)}, st);
                while (st != ST_REFUSED);
                repeat (2) send_item(ACT_PULL, $urandom, st);
                send_item(ACT_END, $urandom, st);
            end
            2: begin
                ending = "zero-length command";
                send_item(ACT_PUSH, {16'h0000, 16'($urandom)}, st);
            end
            default: begin
                ending = "length error";
                if ($urandom_range(0, 1) == 0)
                    send_item(ACT_PUSH, {16'h0001, 16'($urandom)}, st);
                else
                    send_item(ACT_PUSH, {16'($urandom_range(200, 65535)), 16'($urandom)}, st);
            end
        endcase
        send_item(ACT_PUSH, $urandom, st);
        send_item(ACT_END, $urandom, st);
        while (sb.used > 0) send_item(ACT_PULL, $urandom, st);
        send_item(ACT_PUSH, $urandom, st);
        send_item(ACT_END, $urandom, st);
        send_item(ACT_PULL, $urandom, st);
        send_item(ACT_NONE, $urandom, st);
        settle();
        repeat (8) @(posedge aclk);

        $display("Run: %0d transactions, %0d results compared, %0d tag writes, four idling mixes,",
                 sent, sb.checked, tag_writes);
        $display("stream closed by %s.", ending);
        if (sb.errors == 0 && sb.beats.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/ccf_pkg.sv
hdl/ccf_frame_ram.sv
hdl/ccf_ctrl.sv
hdl/command_chunk_framer.sv
hdl/ccf_checker.sv
bench/tb.sv
